// ===== rtl/uhr_pkg.sv =====
`timescale 1ns / 1ps

package uhr_pkg;

    // Kernel and history depth per source
    localparam int MAX_TAPS = 64;
    localparam int NUM_SRC  = 3;

    // Field widths
    localparam int OPCODE_W = 1;
    localparam int SRC_W    = 2;
    localparam int TAP_W    = 6;
    localparam int COEF_W   = 16;
    localparam int SAMPLE_W = 16;
    localparam int TAPS_W   = 7;
    localparam int FLOW_W   = 24;
    localparam int FRAC_W   = 16;
    localparam int CFG_IDX_W = 2;

    // Derived widths
    localparam int LAG_W   = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int CNT_W   = $clog2(MAX_TAPS + 1);
    localparam int KDEPTH  = NUM_SRC * MAX_TAPS;
    localparam int KADDR_W = (KDEPTH > 1) ? $clog2(KDEPTH) : 1;
    localparam int PROD_W  = SAMPLE_W + COEF_W;
    localparam int ACC_W   = PROD_W + $clog2(KDEPTH) + 1;
    localparam int SH_W    = ACC_W - FRAC_W;

    localparam logic [FLOW_W-1:0] OUT_MAX = {FLOW_W{1'b1}};

    // Opcodes
    localparam logic [OPCODE_W-1:0] OP_LOAD   = 1'b0;
    localparam logic [OPCODE_W-1:0] OP_SAMPLE = 1'b1;

    // Source codes
    localparam logic [SRC_W-1:0] SRC_LAND   = 2'd0;
    localparam logic [SRC_W-1:0] SRC_SOIL   = 2'd1;
    localparam logic [SRC_W-1:0] SRC_GROUND = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TAPS_LAND   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TAPS_SOIL   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TAPS_GROUND = 2'd2;

    typedef logic [NUM_SRC-1:0][SAMPLE_W-1:0] hist_row_t;

endpackage

// ===== rtl/uhr_item_if.sv =====
`timescale 1ns / 1ps

interface uhr_item_if import uhr_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [OPCODE_W-1:0] opcode;
    logic [SRC_W-1:0]    coef_source;
    logic [TAP_W-1:0]    coef_tap;
    logic [COEF_W-1:0]   coef_value;
    logic [SAMPLE_W-1:0] land_sample;
    logic [SAMPLE_W-1:0] soil_sample;
    logic [SAMPLE_W-1:0] ground_sample;

    modport source (output valid, opcode, coef_source, coef_tap, coef_value,
                    land_sample, soil_sample, ground_sample, input ready);
    modport sink   (input valid, opcode, coef_source, coef_tap, coef_value,
                    land_sample, soil_sample, ground_sample, output ready);
endinterface

// ===== rtl/uhr_result_if.sv =====
`timescale 1ns / 1ps

interface uhr_result_if import uhr_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [FLOW_W-1:0] routed_flow;

    modport source (output valid, routed_flow, input ready);
    modport sink   (input valid, routed_flow, output ready);
endinterface

// ===== rtl/three_source_unit_hydrograph_routing.sv =====
`timescale 1ns / 1ps

// Three-source unit hydrograph router.
// Input channel "item": a transaction with opcode OP_LOAD writes one kernel
// coefficient (source, tap, Q0.16 value) and gives no result.
// A transaction with opcode OP_SAMPLE pushes the three fluxes into their
// histories and gives one routed_flow on channel "result".
// Configuration: cfg_we/cfg_index/cfg_data write the tap counts of land, soil
// and ground (0 disables a source); write only while the block is idle.
// One 16x16 multiply-accumulate is shared by all taps of all sources, one tap
// per cycle, so the block takes no new item while a sample is in progress:
// item.ready stays low until its sum is loaded into the output register.
// After a coefficient load the block stays idle and ready for the next item.
// The result sits in an output register; the block keeps accepting items
// while it waits. If the receiver stalls, a finished sum holds in the
// sequencer until the output register frees up.
// Reset clears the tap counts, the history fill count and the kernel valid
// bits, so history and kernels read as zero until written. No clearing pass.
module three_source_unit_hydrograph_routing import uhr_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [TAPS_W-1:0]    cfg_data,
    uhr_item_if.sink             item,
    uhr_result_if.source         result
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_RUN   = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_DONE  = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [TAPS_W-1:0] taps_land_reg, taps_soil_reg, taps_ground_reg;

    logic [LAG_W-1:0] wptr_reg, wptr_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic [SRC_W-1:0] src_reg, src_next;
    logic [LAG_W-1:0] lag_reg, lag_next;

    // Memories
    hist_row_t         hmem [MAX_TAPS];
    logic [COEF_W-1:0] kmem [KDEPTH];
    logic [KDEPTH-1:0] kvld_reg;

    // Pipeline registers
    hist_row_t         hrow_reg;
    logic [COEF_W-1:0] kdata_reg;
    logic              kok_reg;
    logic              hok_reg;
    logic [SRC_W-1:0]  hsel_reg;
    logic              iss_reg;
    logic [PROD_W-1:0] prod_reg;
    logic              prod_vld_reg;
    logic [ACC_W-1:0]  acc_reg;

    logic              out_vld_reg;
    logic [FLOW_W-1:0] out_flow_reg;

    logic              in_fire, out_fire, load_fire, sample_fire;
    logic              issue, src_done, out_load;
    logic [TAPS_W-1:0] taps_sel;
    logic [CNT_W-1:0]  taps_eff;
    logic [KADDR_W-1:0] kaddr_rd, kaddr_wr;
    logic              kload_ok;
    logic [LAG_W-1:0]  haddr;
    logic [SH_W-1:0]   acc_sh;
    logic [FLOW_W-1:0] flow_sat;
    logic [SAMPLE_W-1:0] hval;
    logic [COEF_W-1:0]   kval;

    assign in_fire     = item.valid && item.ready;
    assign out_fire    = result.valid && result.ready;
    assign load_fire   = in_fire && (item.opcode == OP_LOAD);
    assign sample_fire = in_fire && (item.opcode == OP_SAMPLE);

    assign item.ready         = (state_reg == ST_IDLE);
    assign result.valid       = out_vld_reg;
    assign result.routed_flow = out_flow_reg;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            taps_land_reg   <= '0;
            taps_soil_reg   <= '0;
            taps_ground_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_TAPS_LAND:   taps_land_reg   <= cfg_data;
                CFG_TAPS_SOIL:   taps_soil_reg   <= cfg_data;
                CFG_TAPS_GROUND: taps_ground_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Select and saturate the tap count of the current source
    always_comb
    begin
        case (src_reg)
            SRC_LAND:   taps_sel = taps_land_reg;
            SRC_SOIL:   taps_sel = taps_soil_reg;
            SRC_GROUND: taps_sel = taps_ground_reg;
            default:    taps_sel = '0;
        endcase
        if (int'(taps_sel) > MAX_TAPS)
            taps_eff = CNT_W'(MAX_TAPS);
        else
            taps_eff = CNT_W'(taps_sel);
    end

    // Sequencer step: one tap per cycle; a disabled source issues no tap
    assign issue    = (state_reg == ST_RUN) && (CNT_W'(lag_reg) < taps_eff);
    assign src_done = (state_reg == ST_RUN) &&
                      (!issue || (CNT_W'(lag_reg) + CNT_W'(1) == taps_eff));
    assign out_load = (state_reg == ST_DONE) && (!out_vld_reg || result.ready);

    always_comb
    begin
        state_next = state_reg;
        src_next   = src_reg;
        lag_next   = lag_reg;
        wptr_next  = wptr_reg;
        fill_next  = fill_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (sample_fire)
                begin
                    state_next = ST_RUN;
                    src_next   = SRC_LAND;
                    lag_next   = '0;
                    if (int'(fill_reg) < MAX_TAPS)
                        fill_next = fill_reg + CNT_W'(1);
                end
            end
            ST_RUN:
            begin
                if (src_done)
                begin
                    lag_next = '0;
                    if (src_reg == SRC_GROUND)
                        state_next = ST_DRAIN;
                    else
                        src_next = src_reg + SRC_W'(1);
                end
                else
                    lag_next = lag_reg + LAG_W'(1);
            end
            ST_DRAIN:
            begin
                if (!iss_reg && !prod_vld_reg)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                    if (int'(wptr_reg) == MAX_TAPS - 1)
                        wptr_next = '0;
                    else
                        wptr_next = wptr_reg + LAG_W'(1);
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            src_reg   <= SRC_LAND;
            lag_reg   <= '0;
            wptr_reg  <= '0;
            fill_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            src_reg   <= src_next;
            lag_reg   <= lag_next;
            wptr_reg  <= wptr_next;
            fill_reg  <= fill_next;
        end
    end

    // Addresses: kernel by source and lag, history backward from newest row
    assign kaddr_rd = KADDR_W'(int'(src_reg) * MAX_TAPS + int'(lag_reg));
    assign kaddr_wr = KADDR_W'(int'(item.coef_source) * MAX_TAPS + int'(item.coef_tap));
    assign kload_ok = (int'(item.coef_source) < NUM_SRC) && (int'(item.coef_tap) < MAX_TAPS);

    always_comb
    begin
        if (lag_reg <= wptr_reg)
            haddr = wptr_reg - lag_reg;
        else
            haddr = LAG_W'(int'(wptr_reg) + MAX_TAPS - int'(lag_reg));
    end

    // History memory: write the newest row on a sample, read one row per tap
    always_ff @(posedge clk)
    begin
        if (sample_fire)
            hmem[wptr_reg] <= {item.ground_sample, item.soil_sample, item.land_sample};
        hrow_reg <= hmem[haddr];
    end

    // Kernel memory: write on a load, read one coefficient per tap
    always_ff @(posedge clk)
    begin
        if (load_fire && kload_ok)
            kmem[kaddr_wr] <= item.coef_value;
        kdata_reg <= kmem[kaddr_rd];
    end

    // Kernel valid bits: an unwritten coefficient reads as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            kvld_reg <= '0;
        else if (load_fire && kload_ok)
            kvld_reg[kaddr_wr] <= 1'b1;
    end

    // Read stage side information
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iss_reg      <= 1'b0;
            prod_vld_reg <= 1'b0;
        end
        else
        begin
            iss_reg      <= issue;
            prod_vld_reg <= iss_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        kok_reg  <= kvld_reg[kaddr_rd];
        hok_reg  <= (CNT_W'(lag_reg) < fill_reg);
        hsel_reg <= src_reg;
    end

    // Mask operands that were never written
    assign hval = hok_reg ? hrow_reg[hsel_reg] : '0;
    assign kval = kok_reg ? kdata_reg : '0;

    // Shared multiply, then accumulate
    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(hval) * PROD_W'(kval);
        if (sample_fire)
            acc_reg <= '0;
        else if (prod_vld_reg)
            acc_reg <= acc_reg + ACC_W'(prod_reg);
    end

    // Drop the fraction and saturate
    assign acc_sh = acc_reg[ACC_W-1:FRAC_W];
    always_comb
    begin
        if (64'(acc_sh) > 64'(OUT_MAX))
            flow_sat = OUT_MAX;
        else
            flow_sat = FLOW_W'(acc_sh);
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (out_load)
            out_vld_reg <= 1'b1;
        else if (out_fire)
            out_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
            out_flow_reg <= flow_sat;
    end

    // Checks
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(fill_reg) <= MAX_TAPS)
        else $error("history fill count above depth");

    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (!iss_reg && !prod_vld_reg))
        else $error("multiply pipeline busy while idle");

    a_result_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (result.valid && result.routed_flow == $past(flow_sat)))
        else $error("finished sum not presented");

    a_src_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> (src_reg == SRC_LAND || src_reg == SRC_SOIL ||
                                   src_reg == SRC_GROUND))
        else $error("sequencer source out of range");

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import uhr_pkg::*;

    localparam int LIMIT_CYCLES   = 5000;
    localparam int DRAIN_CYCLES   = NUM_SRC * MAX_TAPS + 8;
    localparam int RX_HOLD_CYCLES = 400;
    localparam int TARGET_ITEMS   = 850;
    localparam int QUIET_ITEMS    = 80;
    localparam int PHASE_ITEMS    = 60;
    localparam int TAPS_TOP       = (1 << TAPS_W) - 1;

    // Codes the package leaves unnamed: both must be ignored by the block
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam logic [SRC_W-1:0]     SRC_NONE   = 2'd3;

    typedef struct {
        logic [OPCODE_W-1:0] opcode;
        logic [SRC_W-1:0]    coef_source;
        logic [TAP_W-1:0]    coef_tap;
        logic [COEF_W-1:0]   coef_value;
        logic [SAMPLE_W-1:0] land_sample;
        logic [SAMPLE_W-1:0] soil_sample;
        logic [SAMPLE_W-1:0] ground_sample;
    } uhr_txn_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [TAPS_W-1:0]    cfg_data;

    uhr_item_if   item_ch ();
    uhr_result_if result_ch ();

    three_source_unit_hydrograph_routing DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (item_ch),
        .result    (result_ch)
    );

    // Shadow of the router: flux histories, kernels and tap counts
    logic [SAMPLE_W-1:0] flux_hist [NUM_SRC][MAX_TAPS];
    logic [COEF_W-1:0]   kernel_sh [NUM_SRC][MAX_TAPS];
    logic [TAPS_W-1:0]   taps_sh   [NUM_SRC];

    logic [FLOW_W-1:0] flow_q [$];
    uhr_txn_t          item_q [$];

    int       err_count;
    int       queued_items;
    int       hold_req;
    int       hold_seen;
    int       hold_cnt;
    int       tx_gap;
    int       rx_gap;
    int       stall_cycles;
    bit       idle_en;
    uhr_txn_t tx_next;
    uhr_txn_t tx_seen;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    task automatic flag_error(input string msg);
        err_count++;
        $display("tb: mismatch at %0t ns: %s", $time, msg);
    endtask

    // Advance the shadow by one accepted transaction; queue the routed flow
    function automatic void route_predict(input uhr_txn_t t);
        logic [63:0] acc;
        logic [63:0] prod;
        int          s;
        int          j;
        int          n;
        if (t.opcode == OP_LOAD)
        begin
            if (t.coef_source < NUM_SRC)
                kernel_sh[t.coef_source][t.coef_tap] = t.coef_value;
            return;
        end
        for (s = 0; s < NUM_SRC; s++)
            for (j = MAX_TAPS - 1; j > 0; j--)
                flux_hist[s][j] = flux_hist[s][j-1];
        flux_hist[SRC_LAND][0]   = t.land_sample;
        flux_hist[SRC_SOIL][0]   = t.soil_sample;
        flux_hist[SRC_GROUND][0] = t.ground_sample;
        acc = '0;
        for (s = 0; s < NUM_SRC; s++)
        begin
            n = int'(taps_sh[s]);
            if (n > MAX_TAPS)
                n = MAX_TAPS;
            for (j = 0; j < n; j++)
            begin
                prod = 64'(flux_hist[s][j]);
                prod = prod * 64'(kernel_sh[s][j]);
                acc  = acc + prod;
            end
        end
        acc = acc >> FRAC_W;
        if (acc > 64'(OUT_MAX))
            acc = 64'(OUT_MAX);
        flow_q.push_back(acc[FLOW_W-1:0]);
    endfunction

    function automatic logic [15:0] pick_word();
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [TAPS_W-1:0] pick_taps();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return TAPS_W'(MAX_TAPS);
            2:       return TAPS_W'($urandom_range(MAX_TAPS + 1, TAPS_TOP));
            default: return TAPS_W'($urandom_range(1, 12));
        endcase
    endfunction

    function automatic logic [SRC_W-1:0] pick_source();
        if ($urandom_range(0, 15) == 0)
            return SRC_NONE;
        case ($urandom_range(0, 2))
            0:       return SRC_LAND;
            1:       return SRC_SOIL;
            default: return SRC_GROUND;
        endcase
    endfunction

    // Random transaction; fields unused by its opcode carry noise as well
    function automatic uhr_txn_t rand_txn();
        uhr_txn_t t;
        t.opcode        = ($urandom_range(0, 99) < 65) ? OP_SAMPLE : OP_LOAD;
        t.coef_source   = pick_source();
        t.coef_tap      = $urandom_range(0, 1) ? TAP_W'($urandom_range(0, MAX_TAPS - 1))
                                               : TAP_W'($urandom_range(0, 11));
        t.coef_value    = pick_word();
        t.land_sample   = pick_word();
        t.soil_sample   = pick_word();
        t.ground_sample = pick_word();
        return t;
    endfunction

    function automatic uhr_txn_t mk_load(input logic [SRC_W-1:0] src,
                                         input logic [TAP_W-1:0] tap,
                                         input logic [COEF_W-1:0] val);
        uhr_txn_t t;
        t             = rand_txn();
        t.opcode      = OP_LOAD;
        t.coef_source = src;
        t.coef_tap    = tap;
        t.coef_value  = val;
        return t;
    endfunction

    function automatic uhr_txn_t mk_sample(input logic [SAMPLE_W-1:0] land,
                                           input logic [SAMPLE_W-1:0] soil,
                                           input logic [SAMPLE_W-1:0] ground);
        uhr_txn_t t;
        t               = rand_txn();
        t.opcode        = OP_SAMPLE;
        t.land_sample   = land;
        t.soil_sample   = soil;
        t.ground_sample = ground;
        return t;
    endfunction

    task automatic queue_txn(input uhr_txn_t t);
        item_q.push_back(t);
        queued_items++;
    endtask

    // Write one tap count; only called while the router is idle
    task automatic write_taps(input logic [CFG_IDX_W-1:0] idx,
                              input logic [TAPS_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx < NUM_SRC)
            taps_sh[idx] = val;
    endtask

    // Hold until every queued transaction went in and every flow came out
    task automatic drain_block();
        while (item_q.size() != 0 || item_ch.valid || flow_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Driver: offer queued transactions, with random gaps between them
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_ch.valid <= 1'b0;
            tx_gap = 0;
        end
        else
        begin
            if (item_ch.valid && item_ch.ready)
            begin
                tx_seen.opcode        = item_ch.opcode;
                tx_seen.coef_source   = item_ch.coef_source;
                tx_seen.coef_tap      = item_ch.coef_tap;
                tx_seen.coef_value    = item_ch.coef_value;
                tx_seen.land_sample   = item_ch.land_sample;
                tx_seen.soil_sample   = item_ch.soil_sample;
                tx_seen.ground_sample = item_ch.ground_sample;
                route_predict(tx_seen);
            end
            if (!item_ch.valid || item_ch.ready)
            begin
                if (tx_gap > 0)
                begin
                    tx_gap--;
                    item_ch.valid <= 1'b0;
                end
                else if (item_q.size() > 0)
                begin
                    tx_next = item_q.pop_front();
                    item_ch.valid         <= 1'b1;
                    item_ch.opcode        <= tx_next.opcode;
                    item_ch.coef_source   <= tx_next.coef_source;
                    item_ch.coef_tap      <= tx_next.coef_tap;
                    item_ch.coef_value    <= tx_next.coef_value;
                    item_ch.land_sample   <= tx_next.land_sample;
                    item_ch.soil_sample   <= tx_next.soil_sample;
                    item_ch.ground_sample <= tx_next.ground_sample;
                    if (idle_en && $urandom_range(0, 9) == 0)
                        tx_gap = $urandom_range(1, 18);
                end
                else
                begin
                    item_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each routed flow, stall the result side at random
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
            rx_gap    = 0;
            hold_cnt  = 0;
            hold_seen = 0;
        end
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                if (flow_q.size() == 0)
                    flag_error($sformatf("routed_flow %0d with no sample pending",
                                         result_ch.routed_flow));
                else if (result_ch.routed_flow !== flow_q[0])
                    flag_error($sformatf("routed_flow got %0d exp %0d",
                                         result_ch.routed_flow, flow_q.pop_front()));
                else
                    void'(flow_q.pop_front());
            end
            if (hold_seen != hold_req)
            begin
                hold_seen = hold_req;
                hold_cnt  = RX_HOLD_CYCLES;
            end
            if (hold_cnt > 0)
            begin
                hold_cnt--;
                result_ch.ready <= 1'b0;
            end
            else if (rx_gap > 0)
            begin
                rx_gap--;
                result_ch.ready <= 1'b0;
            end
            else
            begin
                result_ch.ready <= 1'b1;
                if (idle_en && $urandom_range(0, 11) == 0)
                    rx_gap = $urandom_range(1, 18);
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || cfg_we || (item_ch.valid && item_ch.ready) ||
            (result_ch.valid && result_ch.ready))
        begin
            stall_cycles <= 0;
        end
        else if (stall_cycles >= LIMIT_CYCLES)
        begin
            $display("tb: failure");
            $finish;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial
    begin
        int s;
        int j;
        int phase;
        int k;

        rst_n                 = 1'b0;
        cfg_we                = 1'b0;
        cfg_index             = '0;
        cfg_data              = '0;
        item_ch.valid         = 1'b0;
        item_ch.opcode        = OP_LOAD;
        item_ch.coef_source   = SRC_LAND;
        item_ch.coef_tap      = '0;
        item_ch.coef_value    = '0;
        item_ch.land_sample   = '0;
        item_ch.soil_sample   = '0;
        item_ch.ground_sample = '0;
        result_ch.ready       = 1'b0;
        stall_cycles          = 0;
        err_count             = 0;
        queued_items          = 0;
        hold_req              = 0;
        idle_en               = 1'b1;
        for (s = 0; s < NUM_SRC; s++)
        begin
            taps_sh[s] = '0;
            for (j = 0; j < MAX_TAPS; j++)
            begin
                flux_hist[s][j] = '0;
                kernel_sh[s][j] = '0;
            end
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // All sources disabled after reset: flow is zero, histories still shift
        @(negedge clk);
        queue_txn(mk_sample(16'hFFFF, 16'hFFFF, 16'hFFFF));
        queue_txn(mk_load(SRC_LAND, TAP_W'(0), 16'hFFFF));
        drain_block();

        // Short kernels; a write to the unused index must change nothing
        write_taps(CFG_TAPS_LAND, TAPS_W'(3));
        write_taps(CFG_TAPS_SOIL, TAPS_W'(2));
        write_taps(CFG_TAPS_GROUND, TAPS_W'(1));
        write_taps(CFG_UNUSED, TAPS_W'(5));
        @(negedge clk);
        queue_txn(mk_load(SRC_LAND, TAP_W'(1), 16'h8000));
        queue_txn(mk_load(SRC_LAND, TAP_W'(2), 16'h0001));
        queue_txn(mk_load(SRC_SOIL, TAP_W'(0), 16'hFFFF));
        queue_txn(mk_load(SRC_GROUND, TAP_W'(0), 16'h1234));
        queue_txn(mk_load(SRC_NONE, TAP_W'(0), 16'hFFFF));
        queue_txn(mk_load(SRC_SOIL, TAP_W'(MAX_TAPS - 1), 16'hFFFF));
        queue_txn(mk_sample(16'hFFFF, 16'hFFFF, 16'hFFFF));
        queue_txn(mk_sample(16'h0000, 16'h0000, 16'h0000));
        queue_txn(mk_load(SRC_LAND, TAP_W'(0), 16'h0000));
        queue_txn(mk_sample(16'h0001, 16'h8000, 16'hFFFF));
        queue_txn(mk_sample(16'h1234, 16'h5678, 16'h9ABC));
        drain_block();

        // Count above the kernel depth saturates; count at depth; one disabled
        write_taps(CFG_TAPS_LAND, TAPS_W'(TAPS_TOP));
        write_taps(CFG_TAPS_SOIL, TAPS_W'(MAX_TAPS));
        write_taps(CFG_TAPS_GROUND, TAPS_W'(0));
        @(negedge clk);
        queue_txn(mk_load(SRC_GROUND, TAP_W'(5), 16'hFFFF));
        queue_txn(mk_sample(16'hFFFF, 16'hFFFF, 16'hFFFF));
        queue_txn(mk_sample(16'hFFFF, 16'h0000, 16'hFFFF));
        queue_txn(mk_sample(16'h0000, 16'hFFFF, 16'h0000));
        queue_txn(mk_sample(16'hA5A5, 16'h5A5A, 16'hFFFF));
        drain_block();

        // Random phases, each under a fresh set of tap counts
        phase = 0;
        while (queued_items < TARGET_ITEMS)
        begin
            if (phase == 3)
            begin
                write_taps(CFG_TAPS_LAND, TAPS_W'(MAX_TAPS));
                write_taps(CFG_TAPS_SOIL, TAPS_W'(TAPS_TOP));
                write_taps(CFG_TAPS_GROUND, TAPS_W'(MAX_TAPS));
            end
            else
            begin
                write_taps(CFG_TAPS_LAND, pick_taps());
                write_taps(CFG_TAPS_SOIL, pick_taps());
                write_taps(CFG_TAPS_GROUND, pick_taps());
                if ($urandom_range(0, 3) == 0)
                    write_taps(CFG_UNUSED, TAPS_W'($urandom));
            end
            @(negedge clk);
            // The last stretch runs with no random gaps on either side
            if (TARGET_ITEMS - queued_items <= QUIET_ITEMS)
                idle_en = 1'b0;
            // Stall the result side long enough for the router to back up
            if (phase == 1)
                hold_req++;
            if (phase == 3)
            begin
                // Full-scale kernels and fluxes drive the sum to its largest value
                for (s = 0; s < NUM_SRC; s++)
                    for (j = 0; j < MAX_TAPS; j++)
                        queue_txn(mk_load(SRC_W'(s), TAP_W'(j), 16'hFFFF));
                for (k = 0; k < MAX_TAPS + 4; k++)
                    queue_txn(mk_sample(16'hFFFF, 16'hFFFF, 16'hFFFF));
            end
            else
            begin
                for (k = 0; k < PHASE_ITEMS; k++)
                    queue_txn(rand_txn());
            end
            drain_block();
            phase++;
        end

        if (flow_q.size() != 0)
            flag_error($sformatf("%0d routed flows never arrived", flow_q.size()));
        if (err_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/uhr_pkg.sv
rtl/uhr_item_if.sv
rtl/uhr_result_if.sv
rtl/three_source_unit_hydrograph_routing.sv
dv/tb_top.sv
